### rtl/fsf_pkg.sv
// shared types, constants, microcode store and character tables of the formatter
`timescale 1ns / 1ps
package fsf_pkg;

  localparam int ARG_WIDTH_DEF = 32;
  localparam int WORD_W        = 32;
  localparam int CHAR_W        = 8;
  localparam int COUNT_W       = 31;
  localparam int S_TDATA_W     = 48;
  localparam int M_TDATA_W     = 40;
  localparam int NULL_LEN      = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
  localparam logic [CHAR_W-1:0] CH_S       = 8'h73;
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;

  typedef enum logic [1:0] {
    KIND_FMT,
    KIND_NUM,
    KIND_SBYTE,
    KIND_SEND
  } kind_t;

  // microcode steps
  typedef enum logic [2:0] {
    U_IDLE,
    U_CHAR,
    U_NEG,
    U_DAB,
    U_DIG,
    U_NULL
  } step_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CHAR,
    EM_MINUS,
    EM_DIGIT,
    EM_NULL
  } emit_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DABBLE,
    OP_NIBBLE
  } op_t;

  typedef enum logic [1:0] {
    J_DISPATCH,
    J_GOTO,
    J_LOOP
  } jump_t;

  typedef enum logic [1:0] {
    CS_NONE,
    CS_ARG,
    CS_DIG,
    CS_NULL
  } cnt_sel_t;

  typedef struct packed {
    logic     ready;
    emit_t    emit;
    op_t      op;
    jump_t    jump;
    step_t    target;
    cnt_sel_t cnt_sel;
  } uword_t;

  typedef struct packed {
    logic  stall;
    logic  go;
    step_t target;
  } seq_ctl_t;

  // control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{ready: 1'b0, emit: EM_NONE, op: OP_NONE, jump: J_GOTO, target: U_IDLE,
           cnt_sel: CS_NONE};
    case (s)
      U_IDLE: begin
        w.ready = 1'b1;
        w.jump  = J_DISPATCH;
      end
      U_CHAR: begin
        w.emit = EM_CHAR;
      end
      U_NEG: begin
        w.emit   = EM_MINUS;
        w.target = U_DAB;
      end
      U_DAB: begin
        w.op      = OP_DABBLE;
        w.jump    = J_LOOP;
        w.target  = U_DIG;
        w.cnt_sel = CS_ARG;
      end
      U_DIG: begin
        w.emit    = EM_DIGIT;
        w.op      = OP_NIBBLE;
        w.jump    = J_LOOP;
        w.cnt_sel = CS_DIG;
      end
      U_NULL: begin
        w.emit    = EM_NULL;
        w.jump    = J_LOOP;
        w.cnt_sel = CS_NULL;
      end
      default: begin
        w.jump = J_GOTO;
      end
    endcase
    return w;
  endfunction

  // decimal digits of the largest unsigned value of width w
  function automatic int dec_digits(int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] n);
    logic [CHAR_W-1:0] c;
    if (n < 4'd10) begin
      c = {4'h3, n};
    end else begin
      c = 8'h57 + {4'h0, n};
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] null_char(logic [2:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h75;
      3'd3:    c = 8'h6c;
      3'd4:    c = 8'h6c;
      3'd5:    c = 8'h29;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

### rtl/fsf_useq.sv
// microcode sequencer: step counter, loop counter and jump logic
`timescale 1ns / 1ps
module fsf_useq #(
  parameter int ARG_WIDTH = fsf_pkg::ARG_WIDTH_DEF,
  parameter int CNT_W     = $clog2(ARG_WIDTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  fsf_pkg::seq_ctl_t  ctl,
  output fsf_pkg::uword_t    uword,
  output logic [CNT_W-1:0]   cnt
);
  import fsf_pkg::*;

  localparam int DEC_N = dec_digits(ARG_WIDTH);

  step_t            upc;
  step_t            upc_next;
  logic [CNT_W-1:0] cnt_next;
  uword_t           next_word;

  assign uword = ucode(upc);

  always_comb begin
    upc_next = upc;
    cnt_next = cnt;
    if (!ctl.stall) begin
      case (uword.jump)
        J_DISPATCH: begin
          if (ctl.go) begin
            upc_next = ctl.target;
          end
        end
        J_GOTO: begin
          upc_next = uword.target;
        end
        J_LOOP: begin
          if (cnt != '0) begin
            cnt_next = cnt - 1'b1;
          end else begin
            upc_next = uword.target;
          end
        end
        default: begin
          upc_next = U_IDLE;
        end
      endcase
    end
    next_word = ucode(upc_next);
    // loop count is set on entry to a step
    if (upc_next != upc) begin
      case (next_word.cnt_sel)
        CS_ARG:  cnt_next = CNT_W'(ARG_WIDTH - 1);
        CS_DIG:  cnt_next = CNT_W'(DEC_N - 1);
        CS_NULL: cnt_next = CNT_W'(NULL_LEN - 1);
        default: cnt_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
      cnt <= '0;
    end else begin
      upc <= upc_next;
      cnt <= cnt_next;
    end
  end

endmodule

### rtl/format_string_formatter.sv
// top level of the mini printf formatter: decode, conversion datapath, output register
`timescale 1ns / 1ps
// Takes format bytes and argument items and streams out one character per output item,
// each tagged with the saturating running count and a last flag on the final character
// an input item causes. A plain byte, an escaped byte or a string argument byte is
// accepted, then emitted; a null string end emits the six characters of (null). %x scans
// one digit position per cycle while the output is not stalled, over the decimal digit
// count of ARG_WIDTH (ten at the default width). %d emits a minus sign first for a
// negative argument, runs a shift-and-add-3 binary to decimal conversion, one argument
// bit per cycle, then the same digit scan. A stalled output holds the sequencer in
// place. Items of a kind the current state does not take are accepted and dropped.
module format_string_formatter #(
  parameter int ARG_WIDTH = fsf_pkg::ARG_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fsf_pkg::S_TDATA_W-1:0]   s_tdata,  // char_in, arg_word, null_string
  input  logic [1:0]                      s_tuser,  // kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fsf_pkg::M_TDATA_W-1:0]   m_tdata,  // out_char, total_count
  output logic                            m_tlast
);
  import fsf_pkg::*;

  localparam int CNT_W = $clog2(ARG_WIDTH);
  localparam int DEC_N = dec_digits(ARG_WIDTH);
  localparam int BCD_W = DEC_N * 4;
  localparam int EXT_W = (ARG_WIDTH > WORD_W) ? ARG_WIDTH : WORD_W;

  typedef enum logic [1:0] {
    AW_NONE,
    AW_DEC,
    AW_HEX,
    AW_STR
  } await_t;

  logic [CHAR_W-1:0]    char_in;
  logic [WORD_W-1:0]    arg_word;
  logic                 null_string;
  kind_t                kind;
  logic [EXT_W-1:0]     word_ext;
  logic [ARG_WIDTH-1:0] arg_val;
  logic [ARG_WIDTH-1:0] arg_mag;

  uword_t           uword;
  logic [CNT_W-1:0] cnt;
  seq_ctl_t         seq_ctl;

  logic   pending;
  logic   pending_next;
  await_t awaited;
  await_t awaited_next;
  step_t  d_target;

  logic [CHAR_W-1:0]    char_hold;
  logic [BCD_W-1:0]     bcd;
  logic [ARG_WIDTH-1:0] bin;
  logic [BCD_W-1:0]     bcd_adj;
  logic                 started;

  logic [CHAR_W-1:0]  out_char;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] total_inc;

  logic              accept;
  logic              out_free;
  logic              digit_show;
  logic              emit_req;
  logic              adv;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic [3:0]        top_nib;

  assign char_in     = s_tdata[CHAR_W-1:0];
  assign arg_word    = s_tdata[CHAR_W +: WORD_W];
  assign null_string = s_tdata[CHAR_W + WORD_W];
  assign kind        = kind_t'(s_tuser);
  assign word_ext    = EXT_W'(arg_word);
  assign arg_val     = word_ext[ARG_WIDTH-1:0];
  assign arg_mag     = arg_val[ARG_WIDTH-1] ? (~arg_val + 1'b1) : arg_val;

  fsf_useq #(
    .ARG_WIDTH (ARG_WIDTH),
    .CNT_W     (CNT_W)
  ) u_useq (
    .clk   (clk),
    .rst   (rst),
    .ctl   (seq_ctl),
    .uword (uword),
    .cnt   (cnt)
  );

  assign s_tready = uword.ready;
  assign accept   = s_tvalid && s_tready;

  // dispatch decode of one input item
  always_comb begin
    d_target     = U_IDLE;
    pending_next = pending;
    awaited_next = awaited;
    case (awaited)
      AW_NONE: begin
        if (kind == KIND_FMT) begin
          if (pending) begin
            pending_next = 1'b0;
            case (char_in)
              CH_D:    awaited_next = AW_DEC;
              CH_X:    awaited_next = AW_HEX;
              CH_S:    awaited_next = AW_STR;
              default: d_target     = U_CHAR;
            endcase
          end else if (char_in == CH_PERCENT) begin
            pending_next = 1'b1;
          end else begin
            d_target = U_CHAR;
          end
        end
      end
      AW_DEC, AW_HEX: begin
        if (kind == KIND_NUM) begin
          awaited_next = AW_NONE;
          if (awaited == AW_DEC) begin
            d_target = arg_val[ARG_WIDTH-1] ? U_NEG : U_DAB;
          end else begin
            d_target = U_DIG;
          end
        end
      end
      AW_STR: begin
        if (kind == KIND_SBYTE) begin
          d_target = U_CHAR;
        end else if (kind == KIND_SEND) begin
          awaited_next = AW_NONE;
          d_target     = null_string ? U_NULL : U_IDLE;
        end
      end
      default: begin
        awaited_next = AW_NONE;
      end
    endcase
  end

  // one shift-and-add-3 step
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < DEC_N; i++) begin
      if (bcd[i*4 +: 4] > 4'd4) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
  end

  assign top_nib    = bcd[BCD_W-1 -: 4];
  assign out_free   = !m_tvalid || m_tready;
  // leading zeros are skipped, the last position always shows
  assign digit_show = started || (top_nib != 4'd0) || (cnt == '0);

  always_comb begin
    emit_char = char_hold;
    emit_last = 1'b1;
    emit_req  = 1'b1;
    case (uword.emit)
      EM_CHAR: begin
        emit_char = char_hold;
      end
      EM_MINUS: begin
        emit_char = CH_MINUS;
        emit_last = 1'b0;
      end
      EM_DIGIT: begin
        emit_char = hex_char(top_nib);
        emit_last = (cnt == '0);
        emit_req  = digit_show;
      end
      EM_NULL: begin
        emit_char = null_char(3'(NULL_LEN - 1) - cnt[2:0]);
        emit_last = (cnt == '0);
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign adv       = !(emit_req && !out_free);
  assign total_inc = (total == COUNT_MAX) ? total : total + 1'b1;

  assign seq_ctl.stall  = !adv;
  assign seq_ctl.go     = s_tvalid;
  assign seq_ctl.target = d_target;

  // control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 1'b0;
      awaited  <= AW_NONE;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        pending <= pending_next;
        awaited <= awaited_next;
      end
      if (emit_req && adv) begin
        m_tvalid <= 1'b1;
        total    <= total_inc;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (emit_req && adv) begin
      out_char <= emit_char;
      m_tlast  <= emit_last;
    end
    if (accept) begin
      char_hold <= char_in;
      started   <= 1'b0;
      bin       <= arg_mag;
      bcd       <= (awaited == AW_HEX) ? BCD_W'(arg_val) : '0;
    end else if (adv) begin
      case (uword.op)
        OP_DABBLE: begin
          {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
          started    <= 1'b0;
        end
        OP_NIBBLE: begin
          bcd     <= {bcd[BCD_W-5:0], 4'h0};
          started <= digit_show;
        end
        default: begin
          bcd <= bcd;
        end
      endcase
    end
  end

  assign m_tdata = {1'b0, total, out_char};

endmodule

### rtl/fsf_check.sv
// port-level checks of the formatter and their binding to the top level
`timescale 1ns / 1ps
module fsf_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [fsf_pkg::S_TDATA_W-1:0]   s_tdata,
  input logic [1:0]                      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fsf_pkg::M_TDATA_W-1:0]   m_tdata,
  input logic                            m_tlast
);
  import fsf_pkg::*;

  logic [COUNT_W-1:0] count;
  assign count = m_tdata[CHAR_W +: COUNT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  // the next item shown right after a transfer carries the next count
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) ##1 m_tvalid |->
      (count == COUNT_W'($past(count) + 1'b1)) || ($past(count) == COUNT_MAX))
    else $error("running count did not advance by one");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> count != '0)
    else $error("output item with zero count");

  // a new item is never taken in the middle of an expansion
  a_no_accept_mid: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !(m_tvalid && !m_tlast))
    else $error("input accepted while a non-final item waits");

endmodule

bind format_string_formatter fsf_check u_fsf_check (.*);
